// ===== rtl/core/swrl_pkg.sv =====
// swrl_pkg: shared constants, types and controller codes for the rate limiter
// used by swrl_ctrl, swrl_datapath and sliding_window_rate_limiter
package swrl_pkg;

	localparam int RING_DEPTH_DEF = 16;
	localparam int TIME_WIDTH_DEF = 48;

	localparam int LIMIT_W    = 4;
	localparam int WINDOW_W   = 16;
	localparam int MARGIN_W   = 8;
	localparam int WAIT_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 4'd10;
	localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd1000;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd10;
	localparam logic [WAIT_W-1:0]   WAIT_MAX   = 17'd65790;

	localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_MS     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXAM,
		ST_DECIDE,
		ST_PUSH
	} swrl_state_t;

	typedef struct packed {
		logic latch_now;
		logic rd_en;
		logic rd_next;
		logic capture;
		logic pop;
		logic calc;
		logic push;
	} swrl_cmd_t;

	typedef struct packed {
		logic expired;
		logic count_zero;
		logic last_entry;
		logic out_free;
	} swrl_status_t;

endpackage

// ===== rtl/core/swrl_ram.sv =====
// swrl_ram: generic single-write, single-read ram with registered read data
// no dependencies
module swrl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/swrl_ctrl.sv =====
// swrl_ctrl: sequencing state machine for the rate limiter
// depends on swrl_pkg for state codes and command/status structs
module swrl_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  swrl_pkg::swrl_status_t status,
	output swrl_pkg::swrl_cmd_t    cmd
);

	import swrl_pkg::*;

	swrl_state_t state_q;
	swrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = status.count_zero ? ST_DECIDE : ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_next = ST_EXAM;
			end
			ST_EXAM: begin
				if (!status.expired || status.last_entry) begin
					state_next = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.out_free) begin
					state_next = ST_PUSH;
				end
			end
			ST_PUSH: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.latch_now = in_valid;
			end
			ST_FETCH: begin
				cmd.rd_en = 1'b1;
			end
			ST_EXAM: begin
				cmd.capture = 1'b1;
				cmd.pop     = status.expired;
				cmd.rd_en   = status.expired;
				cmd.rd_next = 1'b1;
			end
			ST_DECIDE: begin
				cmd.calc = 1'b1;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/swrl_datapath.sv =====
// swrl_datapath: config registers, stamp ring, pointers, wait arithmetic and output word
// depends on swrl_pkg and swrl_ram
module swrl_datapath #(
	parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF,
	parameter int TIME_WIDTH = swrl_pkg::TIME_WIDTH_DEF,
	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
	localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [swrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swrl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [TIME_WIDTH-1:0]             now_ms,
	input  swrl_pkg::swrl_cmd_t               cmd,
	output swrl_pkg::swrl_status_t            status,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [swrl_pkg::WAIT_W-1:0]       wait_ms,
	output logic                              overflow,
	output logic [CNT_W-1:0]                  fill_level
);

	import swrl_pkg::*;

	localparam int SUM_W = CNT_W + 1;
	localparam int AHX_W = TIME_WIDTH + WAIT_W;

	logic [LIMIT_W-1:0]    limit_q;
	logic [WINDOW_W-1:0]   window_q;
	logic [MARGIN_W-1:0]   margin_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [PTR_W-1:0]      oldest_q;
	logic [CNT_W-1:0]      count_q;
	logic                  not_ahead_q;
	logic [WINDOW_W-1:0]   elapsed_q;
	logic                  ahead_hi_q;
	logic [WAIT_W-1:0]     ahead_lo_q;
	logic [WAIT_W-1:0]     wait_q;
	logic                  out_valid_q;
	logic [WAIT_W-1:0]     wait_ms_q;
	logic                  overflow_q;
	logic [CNT_W-1:0]      fill_q;

	logic [TIME_WIDTH-1:0] stamp;
	logic [PTR_W-1:0]      oldest_nxt;
	logic [PTR_W-1:0]      rd_addr;
	logic [PTR_W-1:0]      push_slot;
	logic [SUM_W-1:0]      slot_sum;
	logic [SUM_W-1:0]      slot_fix;
	logic                  ring_full;
	logic                  now_ge;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [TIME_WIDTH-1:0] ahead;
	logic [AHX_W-1:0]      ahead_x;
	logic                  wait_due;
	logic [WAIT_W-1:0]     base;
	logic [WAIT_W-1:0]     room;
	logic [WAIT_W:0]       ahead_sum;
	logic [WAIT_W-1:0]     wait_next;

	swrl_ram #(
		.WIDTH(TIME_WIDTH),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (cmd.push),
		.wr_addr(push_slot),
		.wr_data(now_q),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(stamp)
	);

	// ring pointers
	always_comb begin
		oldest_nxt = (oldest_q == PTR_W'(RING_DEPTH - 1)) ? '0 : oldest_q + PTR_W'(1);
		rd_addr    = cmd.rd_next ? oldest_nxt : oldest_q;
		ring_full  = (count_q == CNT_W'(RING_DEPTH));
		slot_sum   = SUM_W'(oldest_q) + SUM_W'(count_q);
		slot_fix   = (slot_sum >= SUM_W'(RING_DEPTH)) ? slot_sum - SUM_W'(RING_DEPTH) : slot_sum;
		push_slot  = ring_full ? oldest_q : slot_fix[PTR_W-1:0];
	end

	// expiry test on the oldest stamp
	always_comb begin
		now_ge  = (now_q >= stamp);
		elapsed = now_q - stamp;
		ahead   = stamp - now_q;
		ahead_x = AHX_W'(ahead);
	end

	assign status.expired    = now_ge && (elapsed > TIME_WIDTH'(window_q));
	assign status.count_zero = (count_q == '0);
	assign status.last_entry = (count_q == CNT_W'(1));
	assign status.out_free   = !out_valid_q || out_ready;

	// wait arithmetic
	always_comb begin
		wait_due  = !status.count_zero &&
			({{LIMIT_W{1'b0}}, count_q} >= {{CNT_W{1'b0}}, limit_q});
		base      = WAIT_W'(window_q) + WAIT_W'(margin_q);
		room      = base - WAIT_W'(elapsed_q);
		ahead_sum = {1'b0, base} + {1'b0, ahead_lo_q};
		if (!wait_due) begin
			wait_next = '0;
		end else if (not_ahead_q) begin
			wait_next = room;
		end else if (ahead_hi_q || (ahead_sum > {1'b0, WAIT_MAX})) begin
			wait_next = WAIT_MAX;
		end else begin
			wait_next = ahead_sum[WAIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RST;
			window_q <= WINDOW_RST;
			margin_q <= MARGIN_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_REQUEST_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_WINDOW_MS:     window_q <= cfg_data[WINDOW_W-1:0];
				CFG_MARGIN_MS:     margin_q <= cfg_data[MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop) begin
				oldest_q <= oldest_nxt;
				count_q  <= count_q - CNT_W'(1);
			end else if (cmd.push) begin
				if (ring_full) begin
					oldest_q <= oldest_nxt;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_now) begin
			now_q <= now_ms;
		end
		if (cmd.capture) begin
			not_ahead_q <= now_ge;
			elapsed_q   <= elapsed[WINDOW_W-1:0];
			ahead_hi_q  <= |ahead_x[AHX_W-1:WAIT_W];
			ahead_lo_q  <= ahead_x[WAIT_W-1:0];
		end
		if (cmd.calc) begin
			wait_q <= wait_next;
		end
		if (cmd.push) begin
			wait_ms_q  <= wait_q;
			overflow_q <= ring_full;
			fill_q     <= ring_full ? count_q : count_q + CNT_W'(1);
		end
	end

	assign out_valid  = out_valid_q;
	assign wait_ms    = wait_ms_q;
	assign overflow   = overflow_q;
	assign fill_level = fill_q;

endmodule

// ===== rtl/core/sliding_window_rate_limiter.sv =====
// sliding_window_rate_limiter: top level, controller plus datapath
// depends on swrl_pkg, swrl_ctrl and swrl_datapath
//
// each input word is one request carrying its millisecond stamp (now_ms); each
// request yields exactly one output word: wait_ms (zero means go now), overflow
// (ring was full, oldest stamp overwritten) and fill_level after recording
// both channels use valid/ready; a word moves when valid and ready are high
// on an empty ring the request goes straight from idle to the wait calculation;
// otherwise the oldest stamp is fetched and each expired stamp is popped, the scan
// stopping at the first live stamp or once the last stored stamp is examined
// the expiry scan reads one stamp per cycle from the ring ram, which sets the rate
// one request is in flight at a time; in_ready is high only while idle
// the result sits in an output register; a new request is taken while it waits,
// and that request holds before recording until the register is free
// configuration registers are written through cfg_write_en/cfg_index/cfg_data;
// the user writes them only while idle, the block does not enforce it; unknown indexes are ignored
// reset empties the ring, clears the pointers and loads limit 10, window 1000 ms
// and margin 10 ms; no clearing pass is needed
module sliding_window_rate_limiter #(
	parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF,
	parameter int TIME_WIDTH = swrl_pkg::TIME_WIDTH_DEF,
	localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [TIME_WIDTH-1:0]           now_ms,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [swrl_pkg::WAIT_W-1:0]     wait_ms,
	output logic                            overflow,
	output logic [CNT_W-1:0]                fill_level
);

	import swrl_pkg::*;

	swrl_cmd_t    cmd;
	swrl_status_t status;

	swrl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	swrl_datapath #(
		.RING_DEPTH(RING_DEPTH),
		.TIME_WIDTH(TIME_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.now_ms      (now_ms),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.wait_ms     (wait_ms),
		.overflow    (overflow),
		.fill_level  (fill_level)
	);

endmodule

// ===== test/tb_sliding_window_rate_limiter.sv =====
`timescale 1ns / 1ps
// tb_sliding_window_rate_limiter: self-checking bench for the sliding window rate limiter
// drives timestamped request words, predicts each wait, overflow and fill level and checks them
// depends on swrl_pkg and sliding_window_rate_limiter
module tb_sliding_window_rate_limiter;
	import swrl_pkg::*;

	localparam int RING = RING_DEPTH_DEF;
	localparam int TW = TIME_WIDTH_DEF;
	localparam int FILL_W = $clog2(RING + 1);
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 4 * (RING + 5);
	localparam int LONG_HOLD = 300;
	localparam int GROUP_ITEMS = 150;

	typedef enum logic [1:0] {
		IDLE_TX_LIGHT,
		IDLE_RX_LIGHT,
		IDLE_NONE
	} idle_profile_t;

	typedef enum logic [1:0] {
		PLAN_REQ,
		PLAN_CFG,
		PLAN_PROFILE
	} plan_kind_t;

	typedef struct {
		plan_kind_t          kind;
		logic [TW-1:0]       stamp;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		idle_profile_t       profile;
	} plan_item_t;

	typedef struct packed {
		logic [WAIT_W-1:0] wait_ms;
		logic              overflow;
		logic [FILL_W-1:0] fill_level;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TW-1:0] now_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WAIT_W-1:0] wait_ms;
	logic overflow;
	logic [FILL_W-1:0] fill_level;

	sliding_window_rate_limiter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.wait_ms(wait_ms),
		.overflow(overflow),
		.fill_level(fill_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	plan_item_t request_plan[$];
	verdict_t pending_verdicts[$];
	idle_profile_t profile = IDLE_TX_LIGHT;
	int mismatches = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	logic [63:0] plan_clock = '0;

	// predicted limiter state
	logic [TW-1:0] stamp_store [RING];
	int head_idx = 0;
	int stamp_fill = 0;
	logic [LIMIT_W-1:0] limit_reg = LIMIT_RST;
	logic [WINDOW_W-1:0] window_reg = WINDOW_RST;
	logic [MARGIN_W-1:0] margin_reg = MARGIN_RST;

	function automatic int tx_idle_pct(idle_profile_t p);
		case (p)
			IDLE_TX_LIGHT: return 38;
			IDLE_RX_LIGHT: return 83;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct(idle_profile_t p);
		case (p)
			IDLE_TX_LIGHT: return 83;
			IDLE_RX_LIGHT: return 38;
			default: return 0;
		endcase
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_REQUEST_LIMIT: limit_reg = d[LIMIT_W-1:0];
			CFG_WINDOW_MS: window_reg = d[WINDOW_W-1:0];
			CFG_MARGIN_MS: margin_reg = d[MARGIN_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic verdict_t predict_verdict(logic [TW-1:0] stamp);
		verdict_t v;
		logic [63:0] now, s, ahead, base, room;
		logic scanning;
		now = 64'(stamp);
		v = '0;
		scanning = 1'b1;
		// expire stamps from the oldest end
		while (scanning && stamp_fill > 0) begin
			s = 64'(stamp_store[head_idx]);
			if (now >= s && now - s > 64'(window_reg)) begin
				head_idx = (head_idx + 1) % RING;
				stamp_fill--;
			end else begin
				scanning = 1'b0;
			end
		end
		if (stamp_fill > 0 && stamp_fill >= int'(limit_reg)) begin
			s = 64'(stamp_store[head_idx]);
			base = 64'(window_reg) + 64'(margin_reg);
			if (s >= now) begin
				ahead = s - now;
				room = (ahead > 64'(WAIT_MAX) - base) ? 64'(WAIT_MAX) : base + ahead;
			end else begin
				room = base - (now - s);
				if (room > 64'(WAIT_MAX))
					room = 64'(WAIT_MAX);
			end
			v.wait_ms = room[WAIT_W-1:0];
		end
		if (stamp_fill >= RING) begin
			stamp_store[head_idx] = stamp;
			head_idx = (head_idx + 1) % RING;
			v.overflow = 1'b1;
		end else begin
			stamp_store[(head_idx + stamp_fill) % RING] = stamp;
			stamp_fill++;
		end
		v.fill_level = FILL_W'(stamp_fill);
		return v;
	endfunction

	task automatic add_request(logic [63:0] stamp);
		plan_item_t it;
		it.kind = PLAN_REQ;
		it.stamp = stamp[TW-1:0];
		it.idx = '0;
		it.data = '0;
		it.profile = IDLE_NONE;
		request_plan = {request_plan, it};
	endtask

	task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		plan_item_t it;
		it.kind = PLAN_CFG;
		it.stamp = '0;
		it.idx = idx;
		it.data = d;
		it.profile = IDLE_NONE;
		request_plan = {request_plan, it};
	endtask

	task automatic add_profile(idle_profile_t p);
		plan_item_t it;
		it.kind = PLAN_PROFILE;
		it.stamp = '0;
		it.idx = '0;
		it.data = '0;
		it.profile = p;
		request_plan = {request_plan, it};
	endtask

	task automatic add_random_group(int lim, int win, int mar, int n);
		logic [CFG_DATA_W-1:0] d;
		int span, pick;
		d = CFG_DATA_W'($urandom);
		d[LIMIT_W-1:0] = lim[LIMIT_W-1:0];
		add_write(CFG_REQUEST_LIMIT, d);
		add_write(CFG_WINDOW_MS, win[WINDOW_W-1:0]);
		d = CFG_DATA_W'($urandom);
		d[MARGIN_W-1:0] = mar[MARGIN_W-1:0];
		add_write(CFG_MARGIN_MS, d);
		span = (lim == 0) ? win : win / lim;
		if ($urandom_range(1) == 1)
			plan_clock = {$urandom, $urandom} >> $urandom_range(16);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 35)
				plan_clock = plan_clock + 64'($urandom_range(win / RING + 1));
			else if (pick < 50)
				plan_clock = plan_clock + 64'($urandom_range(span + 1));
			else if (pick < 63)
				;
			else if (pick < 73)
				plan_clock = plan_clock + 64'($urandom_range(3 * win + 3));
			else if (pick < 81)
				plan_clock = plan_clock + 64'(win) + 64'($urandom_range(2)) - 64'd1;
			else if (pick < 88)
				plan_clock = plan_clock - 64'($urandom_range(win + 1));
			else if (pick < 93)
				plan_clock = {$urandom, $urandom};
			else
				plan_clock = plan_clock + 64'($urandom_range(win / 2 + 1));
			plan_clock = plan_clock & ((64'h1 << TW) - 1);
			add_request(plan_clock);
		end
	endtask

	always @(posedge clk) begin : drive_requests
		plan_item_t head;
		logic nxt_valid, nxt_we;
		logic [TW-1:0] nxt_now;
		logic [CFG_IDX_W-1:0] nxt_idx;
		logic [CFG_DATA_W-1:0] nxt_data;
		idle_profile_t nxt_profile;
		if (arst_n) begin
			nxt_valid = in_valid;
			nxt_now = now_ms;
			nxt_we = 1'b0;
			nxt_idx = cfg_index;
			nxt_data = cfg_data;
			nxt_profile = profile;
			if (in_valid && in_ready) begin
				pending_verdicts = {pending_verdicts, predict_verdict(now_ms)};
				nxt_valid = 1'b0;
			end
			if (pending_verdicts.size() == 0 && !in_valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!nxt_valid && request_plan.size() > 0) begin
				head = request_plan[0];
				case (head.kind)
					PLAN_REQ: begin
						if ($urandom_range(99) >= tx_idle_pct(profile)) begin
							nxt_valid = 1'b1;
							nxt_now = head.stamp;
							request_plan.delete(0);
						end
					end
					PLAN_CFG: begin
						// registers change only once the block has drained
						if (quiet_cycles >= SETTLE_CYCLES) begin
							nxt_we = 1'b1;
							nxt_idx = head.idx;
							nxt_data = head.data;
							apply_register(head.idx, head.data);
							request_plan.delete(0);
						end
					end
					default: begin
						nxt_profile = head.profile;
						request_plan.delete(0);
					end
				endcase
			end
			in_valid <= nxt_valid;
			now_ms <= nxt_now;
			cfg_write_en <= nxt_we;
			cfg_index <= nxt_idx;
			cfg_data <= nxt_data;
			profile <= nxt_profile;
		end
	end

	always @(posedge clk) begin : watch_results
		verdict_t due, seen;
		logic nxt_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen.wait_ms = wait_ms;
				seen.overflow = overflow;
				seen.fill_level = fill_level;
				results_seen++;
				if (pending_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: wait %0d overflow %0d fill %0d",
							seen.wait_ms, seen.overflow, seen.fill_level);
				end else begin
					due = pending_verdicts[0];
					pending_verdicts.delete(0);
					if (due.wait_ms !== seen.wait_ms || due.overflow !== seen.overflow ||
						due.fill_level !== seen.fill_level) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word %0d exp wait/ovf/fill %0d/%0d/%0d got %0d/%0d/%0d",
								results_seen, due.wait_ms, due.overflow, due.fill_level,
								seen.wait_ms, seen.overflow, seen.fill_level);
					end
				end
				// long back-pressure so the input side stalls
				if (results_seen == 300 || results_seen == 1200)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				nxt_ready = 1'b0;
				hold_left--;
			end else begin
				nxt_ready = ($urandom_range(99) >= rx_idle_pct(profile));
			end
			out_ready <= nxt_ready;
		end
	end

	initial begin
		for (int k = 0; k < 10; k++)
			add_request(64'd0);
		add_request(64'd500);
		add_request(64'd1000);
		add_request(64'd1001);
		add_request(64'd5000);
		add_request(64'd4000);
		add_write(CFG_REQUEST_LIMIT, 16'd0);
		add_request(64'd10000);
		add_request(64'd10000);
		add_write(CFG_REQUEST_LIMIT, 16'd1);
		add_request(64'd9000);
		add_request((64'h1 << TW) - 1);
		add_request(64'd0);
		add_write(CFG_UNMAPPED, 16'hFFFF);
		for (int g = 0; g < 11; g++) begin
			if (g == 4)
				add_profile(IDLE_RX_LIGHT);
			else if (g == 8)
				add_profile(IDLE_NONE);
			case (g)
				0: add_random_group(1, 1, 0, GROUP_ITEMS);
				1: add_random_group(15, 65535, 255, GROUP_ITEMS);
				2: add_random_group(0, 2000, 7, GROUP_ITEMS);
				3: add_random_group(4, 0, 200, GROUP_ITEMS);
				default: add_random_group($urandom_range(15),
					($urandom_range(1) == 1) ? $urandom_range(300, 1) : $urandom_range(65535, 1),
					$urandom_range(255), GROUP_ITEMS);
			endcase
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (request_plan.size() != 0 || in_valid || pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("tb_sliding_window_rate_limiter passed");
		else
			$display("tb_sliding_window_rate_limiter failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_sliding_window_rate_limiter failed");
		$finish;
	end

endmodule
